// File: rtl/sqe_pkg.sv
// Shared types and codes for the stack/queue engine.
package sqe_pkg;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned MODE_W   = 3;
   localparam int unsigned STATUS_W = 3;

   localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PRINT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_SWAP  = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_BADARG = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_SHORT  = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 3'd4;

   // Operation that every cell applies to its value.
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_TOP,
      CELL_APPEND,
      CELL_SHIFT_UP,
      CELL_SWAP,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [VALUE_W-1:0] push_value;
   } cell_cmd_type;

endpackage

// File: rtl/sqe_cell.sv
// One storage cell of the value chain.
module sqe_cell import sqe_pkg::*; #(
   parameter int unsigned IDX = 0,
   parameter int unsigned CW  = 6
) (
   input  logic                      clock,
   input  cell_cmd_type              cmd,
   input  logic [CW-1:0]             count,
   input  logic signed [VALUE_W-1:0] head_value,
   input  logic signed [VALUE_W-1:0] prev_value,
   input  logic signed [VALUE_W-1:0] next_value,
   output logic signed [VALUE_W-1:0] value
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      unique case (cmd.op)
         CELL_HOLD:     value_in = value_ff;
         CELL_PUSH_TOP: value_in = prev_value;
         CELL_APPEND:   value_in = (count == CW'(IDX)) ? cmd.push_value : value_ff;
         CELL_SHIFT_UP: value_in = next_value;
         CELL_SWAP: begin
            if (IDX == 0) value_in = next_value;
            else if (IDX == 1) value_in = prev_value;
            else value_in = value_ff;
         end
         CELL_ROTATE: begin
            // held range turns one step toward the top, top wraps to the tail
            if (CW'(IDX + 1) == count) value_in = head_value;
            else if (CW'(IDX + 1) < count) value_in = next_value;
            else value_in = value_ff;
         end
         default:       value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// File: rtl/stack_queue_engine_core.sv
// Top level of the stack/queue engine: command port, control and cell chain.
// Push, pop, peek, swap, print-all on an empty store and unused codes: result strobed
// the cycle after start; busy stays low, so one may follow every cycle.
// Print-all with N held values: busy high from the cycle after start while the chain
// rotates once past cell 0; the N beats are registered, so they trail busy.
// Results cannot be stalled. Synchronous active-high reset empties the store
// and clears queue_mode; cell contents are not reset.
module stack_queue_engine_core import sqe_pkg::*; #(
   parameter int unsigned DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   // command beat
   input  logic                       start,
   output logic                       busy,
   input  logic [MODE_W-1:0]          req_mode,
   input  logic signed [VALUE_W-1:0]  req_push_value,
   input  logic                       req_arg_ok,
   // result beat
   output logic                       rsp_strobe,
   output logic signed [VALUE_W-1:0]  rsp_out_value,
   output logic                       rsp_out_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_last,
   // mode register write
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic                       csr_wdata
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_PRINT
   } state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             print_idx_ff, print_idx_in;
   logic                      queue_mode_ff, queue_mode_in;
   logic                      strobe_ff, strobe_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      valid_ff, valid_in;
   logic [STATUS_W-1:0]       status_ff, status_in;
   logic                      last_ff, last_in;

   cell_cmd_type              cmd;
   logic signed [VALUE_W-1:0] cell_value [DEPTH];
   logic                      accept;
   logic                      full;
   logic                      empty;

   assign accept    = start && (state_ff == ST_IDLE);
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign csr_ready = 1'b1;

   // Control: decode the command, pick the chain operation, form the result.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      print_idx_in   = print_idx_ff;
      queue_mode_in  = (csr_valid && csr_ready) ? csr_wdata : queue_mode_ff;
      strobe_in      = 1'b0;
      value_in       = '0;
      valid_in       = 1'b0;
      status_in      = STATUS_OK;
      last_in        = 1'b1;
      cmd.op         = CELL_HOLD;
      cmd.push_value = req_push_value;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               strobe_in = 1'b1;
               unique case (req_mode)
                  MODE_PUSH: begin
                     if (!req_arg_ok) begin
                        status_in = STATUS_BADARG;
                     end else if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        cmd.op   = queue_mode_ff ? CELL_APPEND : CELL_PUSH_TOP;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_PRINT: begin
                     // non-empty: the beats come from the print state
                     if (!empty) begin
                        strobe_in    = 1'b0;
                        state_in     = ST_PRINT;
                        print_idx_in = '0;
                     end
                  end
                  MODE_PEEK: begin
                     valid_in = !empty;
                     value_in = empty ? '0 : cell_value[0];
                  end
                  MODE_POP: begin
                     if (empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        cmd.op   = CELL_SHIFT_UP;
                        count_in = count_ff - CW'(1);
                     end
                  end
                  MODE_SWAP: begin
                     if (count_ff < CW'(2)) status_in = STATUS_SHORT;
                     else cmd.op = CELL_SWAP;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PRINT: begin
            // one element per cycle off the top, chain rotates underneath
            cmd.op       = CELL_ROTATE;
            strobe_in    = 1'b1;
            valid_in     = 1'b1;
            value_in     = cell_value[0];
            last_in      = (print_idx_ff + CW'(1) == count_ff);
            print_idx_in = print_idx_ff + CW'(1);
            if (last_in) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         print_idx_ff  <= '0;
         queue_mode_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         print_idx_ff  <= print_idx_in;
         queue_mode_ff <= queue_mode_in;
         strobe_ff     <= strobe_in;
      end
      value_ff  <= value_in;
      valid_ff  <= valid_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   // Cell chain: cell 0 is the top and takes the push value as its upper neighbor;
   // the tail cell sees itself as its lower neighbor.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] prev_value;
      logic signed [VALUE_W-1:0] next_value;

      if (g == 0) begin : g_first
         assign prev_value = cmd.push_value;
      end else begin : g_mid_prev
         assign prev_value = cell_value[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign next_value = cell_value[g];
      end else begin : g_mid_next
         assign next_value = cell_value[g+1];
      end

      sqe_cell #(
         .IDX (g),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .head_value (cell_value[0]),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[g])
      );
   end

   assign busy          = (state_ff == ST_PRINT);
   assign rsp_strobe    = strobe_ff;
   assign rsp_out_value = value_ff;
   assign rsp_out_valid = valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_last      = last_ff;

`ifndef NO_ASSERTIONS
   // a print run never starts on an empty store
   a_print_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT) |-> (count_ff != '0))
      else $error("print state with empty store");

   // fill level never exceeds the chain length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // a print run delivers its beats back to back
   a_print_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap in print beats");

   // a good push on a store with room grows it by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == MODE_PUSH && req_arg_ok && !full)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not grow store");

   // the run index stays inside the held range
   a_print_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRINT) |-> (print_idx_ff < count_ff))
      else $error("print index past tail");
`endif

endmodule
